FILE: hw/rtl/bkst_pkg.sv
// ---------------------------------------------------------------------------
// bkst_pkg
// Shared widths, request codes, status codes and reset constants of the
// bounded key set table.
// ---------------------------------------------------------------------------
package bkst_pkg;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int POS_W    = 8;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 3;
    localparam int FILL_W   = 9;
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 8;
    localparam int M_DATA_W = 48;

    // Default number of slots
    localparam int CAPACITY_DEF = 16;

    // Slot content and empty marker after reset
    localparam logic [KEY_W-1:0] EMPTY_KEY_RESET = 32'hFFFF_FFFF;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY_KEY = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DUP       = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd5;

endpackage

FILE: hw/rtl/bkst_slot_ram.sv
// ---------------------------------------------------------------------------
// bkst_slot_ram
// Slot store: single write port, single registered read port. A per-entry
// valid bit cleared at reset makes unwritten entries read as the reset
// empty marker.
// ---------------------------------------------------------------------------
module bkst_slot_ram #(
    parameter int DEPTH = bkst_pkg::CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [bkst_pkg::KEY_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [bkst_pkg::KEY_W-1:0] rd_data
);
    import bkst_pkg::*;

    logic [KEY_W-1:0] mem [0:DEPTH-1];
    logic [DEPTH-1:0] valid_reg;
    logic [KEY_W-1:0] rdata_reg;
    logic             rvalid_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg  <= mem[rd_addr];
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    // Mask entries never written
    assign rd_data = rvalid_reg ? rdata_reg : EMPTY_KEY_RESET;

endmodule

FILE: hw/rtl/bounded_key_set_table.sv
// ---------------------------------------------------------------------------
// bounded_key_set_table
// Fixed-capacity set of distinct keys, densely packed, with swap-remove.
// ---------------------------------------------------------------------------
// One request word in, one result word out. Requests are handled one at a
// time; the slot memory is scanned one entry per cycle through its single
// registered read port. Add and lookup go through accept, one compare per
// held key up to the first hit, and result load; delete adds a step to move
// the last key and one to clear its slot, and the rejected cases and
// read-at skip the scan. A new request is taken while the previous result
// still waits in the output register. After reset all slots read as
// 0xFFFFFFFF without any clearing pass. The empty marker register may only
// be written while idle.
// ---------------------------------------------------------------------------
module bounded_key_set_table #(
    parameter int CAPACITY = bkst_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Empty marker register
    input  logic                          cfg_wr_en,
    input  logic [bkst_pkg::KEY_W-1:0]    cfg_wr_data,
    // Request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bkst_pkg::S_DATA_W-1:0] s_tdata,   // key[31:0], position[39:32]
    input  logic [bkst_pkg::S_USER_W-1:0] s_tuser,   // req_type[1:0], zero fill
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bkst_pkg::M_DATA_W-1:0] m_tdata    // status[2:0], found[3],
                                                     // read_key[35:4],
                                                     // fill_count[44:36]
);
    import bkst_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DEL_WR  = 3'd2;
    localparam logic [2:0] S_DEL_CLR = 3'd3;
    localparam logic [2:0] S_RD_WAIT = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]       hit_idx_reg, hit_idx_next;
    logic [STAT_W-1:0]   stat_reg, stat_next;
    logic                found_reg, found_next;
    logic [KEY_W-1:0]    rkey_reg, rkey_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [KEY_W-1:0]    empty_key_reg;

    logic                ram_wr_en, ram_rd_en;
    logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
    logic [KEY_W-1:0]    ram_wr_data, ram_rd_data;

    logic [KEY_W-1:0]    in_key;
    logic [POS_W-1:0]    in_pos;
    logic [REQ_W-1:0]    in_req;
    logic [CW-1:0]       cnt_m1;
    logic [AW-1:0]       last_idx;
    logic                is_full, is_empty, pos_ok, hit, scan_end;

    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_pos   = s_tdata[KEY_W+POS_W-1:KEY_W];
    assign in_req   = s_tuser[REQ_W-1:0];
    assign cnt_m1   = count_reg - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign pos_ok   = ({1'b0, in_pos} < (POS_W+1)'(CAPACITY));
    assign hit      = (ram_rd_data == key_reg);
    assign scan_end = hit || (cmp_idx_reg == last_idx);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    bkst_slot_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_slot_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequence one request through the slot memory
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        cmp_idx_next  = cmp_idx_reg;
        hit_idx_next  = hit_idx_reg;
        stat_next     = stat_reg;
        found_next    = found_reg;
        rkey_next     = rkey_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = count_reg[AW-1:0];
        ram_wr_data   = key_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;

        // Drop the result word once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next     = in_req;
                    key_next     = in_key;
                    cmp_idx_next = '0;
                    stat_next    = STAT_OK;
                    found_next   = 1'b0;
                    rkey_next    = empty_key_reg;
                    state_next   = S_OUT;
                    case (in_req)
                        REQ_ADD: begin
                            if (in_key == empty_key_reg) begin
                                stat_next = STAT_EMPTY_KEY;
                            end else if (is_full) begin
                                stat_next = STAT_FULL;
                            end else if (is_empty) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = '0;
                                ram_wr_data = in_key;
                                count_next  = CW'(1);
                            end else begin
                                ram_rd_en  = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_DELETE: begin
                            if (in_key == empty_key_reg) begin
                                stat_next = STAT_EMPTY_KEY;
                            end else if (is_empty) begin
                                stat_next = STAT_RANGE;
                            end else begin
                                ram_rd_en  = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_LOOKUP: begin
                            if (!is_empty) begin
                                ram_rd_en  = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            if (is_empty || !pos_ok) begin
                                stat_next = STAT_RANGE;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = in_pos[AW-1:0];
                                state_next  = S_RD_WAIT;
                            end
                        end
                    endcase
                end
            end

            // Compare one held key per cycle, fetch the next
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_OUT;
                    case (req_reg)
                        REQ_ADD: begin
                            if (hit) begin
                                stat_next = STAT_DUP;
                            end else begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_DELETE: begin
                            if (hit) begin
                                hit_idx_next = cmp_idx_reg;
                                ram_rd_en    = 1'b1;
                                ram_rd_addr  = last_idx;
                                state_next   = S_DEL_WR;
                            end else begin
                                stat_next = STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                            found_next = hit;
                        end
                    endcase
                end else begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = cmp_idx_reg + AW'(1);
                    cmp_idx_next = cmp_idx_reg + AW'(1);
                end
            end

            // Move the last key into the vacated slot
            S_DEL_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = hit_idx_reg;
                ram_wr_data = ram_rd_data;
                state_next  = S_DEL_CLR;
            end

            // Clear the old last slot and shrink
            S_DEL_CLR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = last_idx;
                ram_wr_data = empty_key_reg;
                count_next  = cnt_m1;
                state_next  = S_OUT;
            end

            S_RD_WAIT: begin
                rkey_next  = ram_rd_data;
                state_next = S_OUT;
            end

            // Load the output register when it is free
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, FILL_W'(count_reg), rkey_reg,
                                     found_reg, stat_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            empty_key_reg <= EMPTY_KEY_RESET;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                empty_key_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        stat_reg    <= stat_next;
        found_reg   <= found_next;
        rkey_reg    <= rkey_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
